>>> hw/rtl/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// shared widths, register indexes and the coefficient generator of the
// high-pass fir
// ----------------------------------------------------------------------------
package fhp_pkg;

	// fixed field widths
	localparam int DATA_W    = 12;
	localparam int DATA_FRAC = 11;
	localparam int GAIN_W    = 12;
	localparam int CODE_W    = 12;
	localparam int CFG_IDX_W = 8;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	// parameter defaults
	localparam int TAPS_DEF      = 141;
	localparam int COEF_BITS_DEF = 18;

	localparam logic [DATA_W-1:0] ADC_MID      = 12'd2048;
	localparam logic [CODE_W-1:0] CODE_MAX     = 12'd4095;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd2000;
	localparam logic [GAIN_W-1:0] OFFSET_RESET = 12'd2048;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 8'd1;

	// filter design constants, q30
	localparam logic [63:0]        CUTOFF_HZ  = 64'd7500;
	localparam logic [63:0]        RATE_HZ    = 64'd200000;
	localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [63:0] INV_PI_Q30 = 64'sd341782638;
	localparam logic signed [63:0] WIN_A_Q30  = 64'sd579820585;
	localparam logic signed [63:0] WIN_B_Q30  = 64'sd493921239;
	localparam logic signed [63:0] ONE_Q30    = 64'sd1073741824;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic issue;
		logic last;
	} mac_ctrl_t;

	typedef struct packed {
		logic signed [63:0] sn;
		logic signed [63:0] cs;
	} sin_cos_t;

	// unsigned quotient by shift and subtract, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// signed quotient truncated toward zero, positive divisor
	function automatic logic signed [63:0] div_s64(input logic signed [63:0] n,
		input logic [63:0] d);
		logic [63:0] mag;
		mag = div_u64((n < 0) ? 64'(-n) : 64'(n), d);
		return (n < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	// signed q30 product, rounded half away from zero
	function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic        neg;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] p;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? 64'(-a) : 64'(a);
		mb  = (b < 0) ? 64'(-b) : 64'(b);
		p   = ((ma * mb) + (64'd1 << 29)) >> 30;
		return neg ? -$signed(p) : $signed(p);
	endfunction

	// sine and cosine in q30 of an angle in turns (32-bit fraction)
	function automatic sin_cos_t sin_cos_q30(input logic [31:0] turns);
		logic [63:0]        r;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        ts;
		logic [63:0]        tc;
		logic [63:0]        dv_s;
		logic [63:0]        dv_c;
		logic signed [63:0] s;
		logic signed [63:0] c;
		sin_cos_t           res;
		r  = {34'd0, turns[29:0]};
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		s  = $signed(ts);
		c  = $signed(tc);
		for (int k = 1; k < 20; k += 2) begin
			dv_s = 64'((k + 1) * (k + 2));
			dv_c = 64'(k * (k + 1));
			ts   = div_u64((ts * x2) >> 30, dv_s);
			tc   = div_u64((tc * x2) >> 30, dv_c);
			if ((k & 2) != 0) begin
				s = s + $signed(ts);
				c = c + $signed(tc);
			end else begin
				s = s - $signed(ts);
				c = c - $signed(tc);
			end
		end
		case (turns[31:30])
			2'd0: begin
				res.sn = s;
				res.cs = c;
			end
			2'd1: begin
				res.sn = c;
				res.cs = -s;
			end
			2'd2: begin
				res.sn = -s;
				res.cs = -c;
			end
			default: begin
				res.sn = -c;
				res.cs = s;
			end
		endcase
		return res;
	endfunction

	// hamming-windowed sinc high-pass tap, signed q1.(coef_bits-1),
	// evaluated at elaboration only
	function automatic logic signed [63:0] coef_value(input int taps, input int coef_bits,
		input int i);
		logic signed [63:0] w;
		logic signed [63:0] lp;
		logic signed [63:0] h;
		logic signed [63:0] q;
		logic signed [63:0] lim;
		logic signed [63:0] two_fc;
		logic [63:0]        den;
		logic [63:0]        am;
		logic [31:0]        ph;
		logic [31:0]        sp;
		sin_cos_t           a;
		sin_cos_t           b;
		int                 mid;
		int                 m;
		int                 shift;
		mid    = taps / 2;
		shift  = 31 - coef_bits;
		lim    = 64'sd1 <<< (coef_bits - 1);
		two_fc = $signed(((64'd2 * CUTOFF_HZ << 30) + RATE_HZ / 2) / RATE_HZ);
		den    = 64'(taps - 1);
		ph     = 32'(div_u64((64'(i) << 32) + den / 2, den));
		m      = i - mid;
		a      = sin_cos_q30(ph);
		w      = WIN_A_Q30 - mul_q30(WIN_B_Q30, a.cs);
		if (m == 0) begin
			lp = mul_q30(two_fc, w);
		end else begin
			am   = 64'((m < 0) ? -m : m);
			sp   = 32'((((am * CUTOFF_HZ) << 32) + RATE_HZ / 2) / RATE_HZ);
			b    = sin_cos_q30(sp);
			lp   = mul_q30(div_s64(mul_q30(b.sn, INV_PI_Q30), am), w);
		end
		h = ((m == 0) ? ONE_Q30 : 64'sd0) - lp;
		if (h < 0) begin
			q = -$signed((64'(-h) + (64'd1 << (shift - 1))) >> shift);
		end else begin
			q = $signed((64'(h) + (64'd1 << (shift - 1))) >> shift);
		end
		if (q > lim - 1) begin
			q = lim - 1;
		end
		if (q < -lim) begin
			q = -lim;
		end
		return q;
	endfunction

endpackage

>>> hw/rtl/fhp_delay_mem.sv
// ----------------------------------------------------------------------------
// fhp_delay_mem
// circular sample delay line with registered read; unwritten slots read zero
// ----------------------------------------------------------------------------
module fhp_delay_mem import fhp_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic signed [DATA_W-1:0] wr_data,
	output logic [$clog2(TAPS)-1:0]  wr_ptr,
	input  logic [$clog2(TAPS)-1:0]  rd_addr,
	output logic signed [DATA_W-1:0] rd_data
);

	localparam int IDX_W  = $clog2(TAPS);
	localparam int FILL_W = $clog2(TAPS + 1);

	logic signed [DATA_W-1:0] mem_q [TAPS];
	logic signed [DATA_W-1:0] rd_data_q;
	logic                     rd_valid_q;
	logic [IDX_W-1:0]         wp_q;
	logic [FILL_W-1:0]        fill_q;

	// pointer and fill count: slots at or above the fill count are still zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == IDX_W'(TAPS - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != FILL_W'(TAPS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			rd_valid_q <= FILL_W'(rd_addr) < fill_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign wr_ptr  = wp_q;
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

>>> hw/rtl/fhp_mac.sv
// ----------------------------------------------------------------------------
// fhp_mac
// shared multiply-accumulate unit with the coefficient table, one tap a clock
// ----------------------------------------------------------------------------
module fhp_mac import fhp_pkg::*; #(
	parameter int TAPS      = TAPS_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF,
	parameter int ACC_W     = DATA_W + COEF_BITS_DEF + $clog2(TAPS_DEF)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctrl_t                ctrl,
	input  logic [$clog2(TAPS)-1:0]  tap,
	input  logic signed [DATA_W-1:0] sample,
	output logic signed [ACC_W-1:0]  acc,
	output logic                     done
);

	localparam int PROD_W = DATA_W + COEF_BITS;

	logic signed [COEF_BITS-1:0] rom_w [TAPS];
	logic signed [COEF_BITS-1:0] coef_s1;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        valid_s1;
	logic                        last_s1;
	logic                        valid_s2;
	logic                        last_s2;
	logic                        done_q;

	// constant coefficient table
	for (genvar g = 0; g < TAPS; g++) begin : g_rom
		localparam logic signed [63:0] CV = coef_value(TAPS, COEF_BITS, g);
		assign rom_w[g] = COEF_BITS'(CV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			last_s1  <= ctrl.issue && ctrl.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			done_q   <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= rom_w[tap];
		prod_s2 <= sample * coef_s1;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

>>> hw/rtl/fhp_scale.sv
// ----------------------------------------------------------------------------
// fhp_scale
// bit-serial gain multiply, offset, round half up and saturate to dac range
// ----------------------------------------------------------------------------
module fhp_scale import fhp_pkg::*; #(
	parameter int ACC_W = DATA_W + COEF_BITS_DEF + $clog2(TAPS_DEF),
	parameter int FRAC  = DATA_FRAC + COEF_BITS_DEF - 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] acc,
	input  logic [GAIN_W-1:0]       gain,
	input  logic [GAIN_W-1:0]       offset,
	output logic                    done,
	output logic [CODE_W-1:0]       dac_code,
	output logic                    clipped
);

	localparam int T_W   = ACC_W + GAIN_W + 1;
	localparam int V_W   = T_W - FRAC;
	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic signed [T_W-1:0] t_q;
	logic signed [T_W-1:0] m_q;
	logic [GAIN_W-1:0]     g_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  fin_q;
	logic                  done_q;
	logic [CODE_W-1:0]     code_q;
	logic                  clip_q;
	logic [V_W-1:0]        v;
	logic [CODE_W-1:0]     sat_code;
	logic                  sat_clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= busy_q && !start && (cnt_q == CNT_W'(1));
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one gain bit per clock, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= (T_W'(offset) << FRAC) + (T_W'(1) << (FRAC - 1));
			m_q <= T_W'(acc);
			g_q <= gain;
		end else if (busy_q) begin
			if (g_q[0]) begin
				t_q <= t_q + m_q;
			end
			m_q <= m_q << 1;
			g_q <= g_q >> 1;
		end
		if (fin_q) begin
			code_q <= sat_code;
			clip_q <= sat_clip;
		end
	end

	assign v = t_q[T_W-1:FRAC];

	always_comb begin
		if (t_q[T_W-1]) begin
			sat_code = '0;
			sat_clip = 1'b1;
		end else if (|v[V_W-1:CODE_W]) begin
			sat_code = CODE_MAX;
			sat_clip = 1'b1;
		end else begin
			sat_code = v[CODE_W-1:0];
			sat_clip = 1'b0;
		end
	end

	assign done     = done_q;
	assign dac_code = code_q;
	assign clipped  = clip_q;

endmodule

>>> hw/rtl/fir_highpass_adc_to_dac.sv
// ----------------------------------------------------------------------------
// fir_highpass_adc_to_dac
// high-pass fir from a 12-bit adc code to a 12-bit dac code
// ----------------------------------------------------------------------------
// Each item on the slave stream is an unsigned adc sample (2048 is zero). It
// is re-centred to signed q1.11, written into a TAPS-deep circular delay line
// that starts out all zero, and filtered by a Hamming-windowed sinc high-pass
// (cutoff 7500 Hz at 200 kHz, signed q1.(COEF_BITS-1) taps built at
// elaboration). The exact sum is scaled as round(y * output_gain +
// output_offset), rounding half up, and saturated to 0..4095; tuser flags an
// item that was clipped. One multiply-accumulate unit walks the taps one per
// clock, then the gain is applied bit-serially. The slave side is ready again
// only once the finished item has moved into the output register, where it
// waits, so the next sample is accepted while that item is still pending.
// Registers: index 0 output_gain (reset 2000), index 1 output_offset (reset
// 2048); writes to other indexes are ignored; write only while idle.
// ----------------------------------------------------------------------------
module fir_highpass_adc_to_dac import fhp_pkg::*; #(
	parameter int TAPS      = TAPS_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	// sample stream in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [11:0] adc_sample, rest zero
	// code stream out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // [11:0] dac_code, rest zero
	output logic                 m_axis_tuser    // [0] clipped
);

	localparam int IDX_W = $clog2(TAPS);
	localparam int ACC_W = DATA_W + COEF_BITS + $clog2(TAPS);
	localparam int FRAC  = DATA_FRAC + COEF_BITS - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_MAC_WAIT,
		ST_SCALE,
		ST_DRAIN
	} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         k_q;        // tap index, newest sample first
	logic [IDX_W-1:0]         rd_addr_q;  // delay line slot for tap k
	logic                     out_valid_q;
	logic [CODE_W-1:0]        out_code_q;
	logic                     out_clip_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [GAIN_W-1:0]        offset_q;

	logic                     in_accept;
	logic                     out_load;
	logic signed [DATA_W-1:0] x_in;
	logic [IDX_W-1:0]         wr_ptr;
	logic signed [DATA_W-1:0] tap_sample;
	mac_ctrl_t                mac_ctrl;
	logic signed [ACC_W-1:0]  acc;
	logic                     mac_done;
	logic                     scale_start;
	logic                     scale_done;
	logic [CODE_W-1:0]        scale_code;
	logic                     scale_clip;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// remove the mid-scale offset, wrap gives the two's complement value
	assign x_in = $signed(s_axis_tdata[DATA_W-1:0] - ADC_MID);

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_OUTPUT_GAIN) begin
				gain_q <= cfg_data;
			end else if (cfg_index == REG_OUTPUT_OFFSET) begin
				offset_q <= cfg_data;
			end
		end
	end

	// tap issue: one read of the delay line and the table per clock in ST_RUN
	assign mac_ctrl.clear = in_accept;
	assign mac_ctrl.issue = (state_q == ST_RUN);
	assign mac_ctrl.last  = (k_q == IDX_W'(TAPS - 1));
	assign scale_start    = (state_q == ST_MAC_WAIT) && mac_done;

	// finished code moves into the output register once that is free
	assign out_load = ((state_q == ST_SCALE && scale_done) || state_q == ST_DRAIN)
		&& (!out_valid_q || m_axis_tready);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rd_addr_q   <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			out_clip_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_code_q  <= scale_code;
				out_clip_q  <= scale_clip;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						// the sample lands in wr_ptr this edge, read it back first
						rd_addr_q <= wr_ptr;
						k_q       <= '0;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					rd_addr_q <= (rd_addr_q == '0) ? IDX_W'(TAPS - 1) : rd_addr_q - 1'b1;
					k_q       <= mac_ctrl.last ? '0 : k_q + 1'b1;
					if (mac_ctrl.last) begin
						state_q <= ST_MAC_WAIT;
					end
				end
				ST_MAC_WAIT: begin
					if (mac_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (scale_done) begin
						state_q <= out_load ? ST_IDLE : ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// scale result holds until the output register frees up
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	fhp_delay_mem #(
		.TAPS (TAPS)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data (x_in),
		.wr_ptr  (wr_ptr),
		.rd_addr (rd_addr_q),
		.rd_data (tap_sample)
	);

	fhp_mac #(
		.TAPS      (TAPS),
		.COEF_BITS (COEF_BITS),
		.ACC_W     (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.tap    (k_q),
		.sample (tap_sample),
		.acc    (acc),
		.done   (mac_done)
	);

	fhp_scale #(
		.ACC_W (ACC_W),
		.FRAC  (FRAC)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scale_start),
		.acc      (acc),
		.gain     (gain_q),
		.offset   (offset_q),
		.done     (scale_done),
		.dac_code (scale_code),
		.clipped  (scale_clip)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_code_q);
	assign m_axis_tuser  = out_clip_q;

	// the accumulator only finishes once every tap has been issued
	a_mac_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_MAC_WAIT)
		else $error("accumulator finished outside the wait state");

	// the scaler only finishes while the sequencer waits for it
	a_scale_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		scale_done |-> state_q == ST_SCALE)
		else $error("scaler finished outside the scale state");

	// tap index and read address stay inside the delay line
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (k_q <= IDX_W'(TAPS - 1)) && (rd_addr_q <= IDX_W'(TAPS - 1)))
		else $error("tap index or read address out of range");

	// a new sample is never accepted while the accumulator or the scaler finishes
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> !mac_done && !scale_done)
		else $error("sample accepted while an item is still in flight");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the high-pass fir from adc code to dac code
// ----------------------------------------------------------------------------
// A queue of adc samples feeds a clocked stream driver. Every sample that the
// block accepts is run through a bit-true model of the filter, so the code
// and clip flag it should produce go into a queue of expected codes. A
// clocked monitor checks each item on the code stream against the oldest
// entry. Both stream sides idle at random, and in two phases the receiver is
// held off for a long stretch so that the block fills up. Gain and offset are
// changed only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_TAPS      = 141;
	localparam int C_BITS      = 18;
	localparam int ACC_FRAC    = 11 + C_BITS - 1;  // scale of one product, q28
	localparam int ROUND_SHIFT = 31 - C_BITS;      // q30 tap down to coefficient width
	localparam int SETTLE      = 200;
	localparam int LONG_HOLD   = 1500;
	localparam int CYCLE_LIMIT = 1000000;

	// indexes that no register answers to
	localparam logic [fhp_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
	localparam logic [fhp_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'd255;

	// filter design constants in q30
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint          Q30_INV_PI  = 64'sd341782638;
	localparam longint          Q30_WIN_A   = 64'sd579820585;
	localparam longint          Q30_WIN_B   = 64'sd493921239;
	localparam longint          Q30_ONE     = 64'sd1073741824;

	typedef struct packed {
		logic [11:0] code;
		logic        clip;
	} dac_result_t;

	// shapes of random sample runs
	typedef enum int {
		WAVE_NOISE,
		WAVE_SQUARE,
		WAVE_DRIFT,
		WAVE_EDGES
	} wave_style_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [fhp_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [fhp_pkg::GAIN_W-1:0]          cfg_data = '0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [fhp_pkg::S_TDATA_W-1:0]       s_axis_tdata = '0;   // [11:0] adc_sample
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [fhp_pkg::M_TDATA_W-1:0]       m_axis_tdata;        // [11:0] dac_code
	logic                                m_axis_tuser;        // [0] clipped

	// model state: delay line, slot for the next sample, taps, registers
	int          adc_line [N_TAPS];
	int          line_slot;
	longint      tap_weight [N_TAPS];
	int          gain_reg;
	int          offset_reg;

	logic [11:0] adc_backlog [$];
	dac_result_t expected_codes [$];
	int          samples_queued = 0;
	int          samples_accepted = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	// handshake marks of the previous rising edge, seen by the falling-edge drivers
	logic        sample_taken = 1'b0;
	logic        code_taken = 1'b0;
	int          send_gap = 0;
	int          ready_hold = 0;
	bit          sender_idles = 1'b0;
	bit          receiver_idles = 1'b0;
	int          long_holds_asked = 0;
	int          long_holds_done = 0;

	fir_highpass_adc_to_dac #(
		.TAPS      (N_TAPS),
		.COEF_BITS (C_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// coefficient generation, integer only so that every tap is exact
	// ------------------------------------------------------------------------

	// signed q30 product, rounded half away from zero
	function automatic longint q30_product(input longint a, input longint b);
		logic                 neg;
		longint unsigned      ma;
		longint unsigned      mb;
		longint unsigned      p;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		p   = (ma * mb + (64'd1 << 29)) >> 30;
		return neg ? -$signed(p) : $signed(p);
	endfunction

	// sine and cosine in q30, angle given in turns as a 32-bit fraction
	function automatic void q30_sincos(input logic [31:0] turns, output longint sn,
		output longint cs);
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint          s;
		longint          c;
		r  = {34'd0, turns[29:0]};
		x  = (r * Q30_HALF_PI) >> 30;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		s  = $signed(ts);
		c  = $signed(tc);
		// taylor series within one quadrant
		for (int k = 1; k < 20; k += 2) begin
			ts = ((ts * x2) >> 30) / 64'((k + 1) * (k + 2));
			tc = ((tc * x2) >> 30) / 64'(k * (k + 1));
			if ((k & 2) != 0) begin
				s = s + $signed(ts);
				c = c + $signed(tc);
			end else begin
				s = s - $signed(ts);
				c = c - $signed(tc);
			end
		end
		case (turns[31:30])
			2'd0: begin
				sn = s;
				cs = c;
			end
			2'd1: begin
				sn = c;
				cs = -s;
			end
			2'd2: begin
				sn = -s;
				cs = -c;
			end
			default: begin
				sn = -c;
				cs = s;
			end
		endcase
	endfunction

	// windowed sinc low-pass, negated, plus one at the middle tap
	function automatic void build_taps();
		longint unsigned den;
		longint unsigned am;
		logic [31:0]     ph;
		logic [31:0]     sp;
		longint          sn;
		longint          cs;
		longint          s2;
		longint          c2;
		longint          w;
		longint          lp;
		longint          h;
		longint          q;
		longint          two_fc;
		longint          lim;
		int              m;
		den    = N_TAPS - 1;
		lim    = 64'sd1 <<< (C_BITS - 1);
		two_fc = $signed((((64'd2 * 64'd7500) << 30) + 64'd100000) / 64'd200000);
		for (int i = 0; i < N_TAPS; i++) begin
			ph = 32'(((64'(i) << 32) + den / 2) / den);
			m  = i - N_TAPS / 2;
			q30_sincos(ph, sn, cs);
			w = Q30_WIN_A - q30_product(Q30_WIN_B, cs);
			if (m == 0) begin
				lp = q30_product(two_fc, w);
			end else begin
				am = (m < 0) ? -m : m;
				sp = 32'((((am * 64'd7500) << 32) + 64'd100000) / 64'd200000);
				q30_sincos(sp, s2, c2);
				lp = q30_product(q30_product(s2, Q30_INV_PI) / $signed(am), w);
			end
			h = ((m == 0) ? Q30_ONE : 64'sd0) - lp;
			// round half away from zero to coefficient width
			if (h < 0) begin
				q = -$signed(((-h) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
			end else begin
				q = $signed((h + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
			end
			if (q > lim - 1) begin
				q = lim - 1;
			end
			if (q < -lim) begin
				q = -lim;
			end
			tap_weight[i] = q;
		end
	endfunction

	// ------------------------------------------------------------------------
	// filter model: one adc sample in, one dac code out
	// ------------------------------------------------------------------------
	function automatic dac_result_t next_dac_code(input logic [11:0] adc);
		longint      acc;
		longint      scaled;
		dac_result_t r;
		acc = 0;
		// re-centre to signed q1.11, newest sample is tap 0
		adc_line[line_slot] = int'(adc) - 2048;
		for (int k = 0; k < N_TAPS; k++) begin
			acc += longint'(adc_line[(line_slot + N_TAPS - k) % N_TAPS]) * tap_weight[k];
		end
		line_slot = (line_slot + 1) % N_TAPS;
		// scale, add offset and round half up
		scaled = acc * longint'(gain_reg) + (longint'(offset_reg) <<< ACC_FRAC)
			+ (64'sd1 <<< (ACC_FRAC - 1));
		if (scaled < 0) begin
			r.code = 12'd0;
			r.clip = 1'b1;
		end else if ((scaled >>> ACC_FRAC) > 4095) begin
			r.code = 12'd4095;
			r.clip = 1'b1;
		end else begin
			r.code = 12'(scaled >>> ACC_FRAC);
			r.clip = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// sample driver, changes the stream at the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		// hold an offered item until it has been taken
		if (arst_n && !(s_axis_tvalid && !sample_taken)) begin
			if (send_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap      <= send_gap - 1;
			end else if (adc_backlog.size() != 0) begin
				s_axis_tdata  <= {4'd0, adc_backlog.pop_front()};
				s_axis_tvalid <= 1'b1;
				send_gap      <= sender_idles ? int'($urandom_range(0, 6)) : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// code receiver: short random waits per item, or one long hold-off
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		int pause;
		if (arst_n) begin
			if (long_holds_done != long_holds_asked) begin
				long_holds_done <= long_holds_asked;
				ready_hold      <= LONG_HOLD;
				m_axis_tready   <= 1'b0;
			end else if (ready_hold != 0) begin
				ready_hold    <= ready_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (code_taken && receiver_idles) begin
				pause         = $urandom_range(0, 6);
				m_axis_tready <= (pause == 0);
				ready_hold    <= (pause == 0) ? 0 : pause - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// rising edge: predict accepted samples, check codes, watch the clock
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		dac_result_t want;
		sample_taken <= s_axis_tvalid && s_axis_tready;
		code_taken   <= m_axis_tvalid && m_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_codes.push_back(next_dac_code(s_axis_tdata[11:0]));
			samples_accepted++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_codes.size() == 0) begin
				mismatch_count++;
				$error("dac_code: expected none, actual %0d", m_axis_tdata[11:0]);
			end else begin
				want = expected_codes.pop_front();
				if (m_axis_tdata[11:0] !== want.code) begin
					mismatch_count++;
					$error("dac_code: expected %0d, actual %0d", want.code,
						m_axis_tdata[11:0]);
				end
				if (m_axis_tuser !== want.clip) begin
					mismatch_count++;
					$error("clipped: expected %0d, actual %0d", want.clip, m_axis_tuser);
				end
			end
		end
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// register write through the configuration channel, block idle
	task automatic write_reg(input logic [fhp_pkg::CFG_IDX_W-1:0] idx,
		input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == fhp_pkg::REG_OUTPUT_GAIN) begin
			gain_reg = int'(val);
		end else if (idx == fhp_pkg::REG_OUTPUT_OFFSET) begin
			offset_reg = int'(val);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every accepted sample has come back as a code
	task automatic wait_drained();
		do @(negedge clk);
		while (samples_accepted != samples_queued || expected_codes.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// runs of noise, square waves, slow drift and edge values
	task automatic queue_random(input int count);
		int          left;
		int          seg;
		int          period;
		int          level;
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] v;
		wave_style_t style;
		left = count;
		while (left > 0) begin
			seg    = $urandom_range(10, 60);
			seg    = (seg > left) ? left : seg;
			style  = wave_style_t'($urandom_range(0, 3));
			lo     = 12'($urandom_range(0, 4095));
			hi     = 12'($urandom_range(0, 4095));
			period = $urandom_range(2, 80);
			level  = $urandom_range(0, 4095);
			for (int n = 0; n < seg; n++) begin
				case (style)
					WAVE_NOISE: begin
						v = 12'($urandom_range(0, 4095));
					end
					WAVE_SQUARE: begin
						v = ((n % period) < period / 2) ? lo : hi;
					end
					WAVE_DRIFT: begin
						level = level + int'($urandom_range(0, 64)) - 32;
						level = (level < 0) ? 0 : ((level > 4095) ? 4095 : level);
						v     = 12'(level);
					end
					default: begin
						case ($urandom_range(0, 4))
							0: v = 12'd0;
							1: v = 12'd4095;
							2: v = 12'd2048;
							3: v = 12'd2047;
							default: v = 12'($urandom_range(0, 4095));
						endcase
					end
				endcase
				adc_backlog.push_back(v);
			end
			samples_queued += seg;
			left -= seg;
		end
	endtask

	// one phase: set idling, queue samples, optional long hold-off, drain
	task automatic run_phase(input int count, input bit tx_idle, input bit rx_idle,
		input bit hold_off);
		@(posedge clk);
		sender_idles   = tx_idle;
		receiver_idles = rx_idle;
		queue_random(count);
		if (hold_off) begin
			repeat (30) @(posedge clk);
			long_holds_asked++;
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [11:0] directed [] = '{12'd2048, 12'd2048, 12'd4095, 12'd0, 12'd4095,
			12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd2048, 12'd2047, 12'd2049,
			12'd1, 12'd4094, 12'h555, 12'hAAA, 12'd2048, 12'd4095, 12'd2048};
		logic [11:0] gain_pick;
		build_taps();
		foreach (adc_line[i]) begin
			adc_line[i] = 0;
		end
		line_slot  = 0;
		gain_reg   = 2000;
		offset_reg = 2048;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of the registers, full-scale steps and edge codes
		@(posedge clk);
		foreach (directed[i]) begin
			adc_backlog.push_back(directed[i]);
		end
		samples_queued += directed.size();
		wait_drained();

		// extreme settings, and writes to indexes that must be ignored
		write_reg(fhp_pkg::REG_OUTPUT_GAIN, 12'd4095);
		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd0);
		write_reg(REG_UNUSED_LOW, 12'd4095);
		write_reg(REG_UNUSED_TOP, 12'd0);
		run_phase(100, 1'b1, 1'b1, 1'b0);

		write_reg(fhp_pkg::REG_OUTPUT_GAIN, 12'd0);
		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd4095);
		run_phase(50, 1'b1, 1'b0, 1'b0);

		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd0);
		run_phase(40, 1'b0, 1'b1, 1'b0);

		write_reg(fhp_pkg::REG_OUTPUT_GAIN, 12'd4095);
		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd4095);
		run_phase(80, 1'b1, 1'b1, 1'b0);

		// unit gain keeps many results near the rounding point
		write_reg(fhp_pkg::REG_OUTPUT_GAIN, 12'd1);
		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd2048);
		run_phase(60, 1'b1, 1'b1, 1'b0);

		// back to reset values, receiver stalls long while samples keep coming
		write_reg(fhp_pkg::REG_OUTPUT_GAIN, 12'd2000);
		write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'd2048);
		run_phase(120, 1'b0, 1'b1, 1'b1);

		// random settings, some near the extremes
		for (int p = 0; p < 7; p++) begin
			case ($urandom_range(0, 3))
				0: gain_pick = 12'($urandom_range(0, 16));
				1: gain_pick = 12'($urandom_range(4000, 4095));
				default: gain_pick = 12'($urandom_range(0, 4095));
			endcase
			write_reg(fhp_pkg::REG_OUTPUT_GAIN, gain_pick);
			write_reg(fhp_pkg::REG_OUTPUT_OFFSET, 12'($urandom_range(0, 4095)));
			run_phase(115, $urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0,
				p == 4);
		end

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
